/* rtl/damm_letter_check_validator_assert.svh */
// Assertion macros for the check-letter validator.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef DAMM_LETTER_CHECK_VALIDATOR_ASSERT_SVH
`define DAMM_LETTER_CHECK_VALIDATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define DLCV_ASSERT(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("dlcv assertion failed");
`define DLCV_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("dlcv assertion failed");
`else
`define DLCV_ASSERT(label, cond)
`define DLCV_ASSERT_NEXT(label, pre, post)
`endif

`endif

/* rtl/dlcv_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dlcv_pkg;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } char_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [6:0] expected_letter;
    } result_item_t;

    // Input register contents handed to the checking stage
    typedef struct packed {
        logic       valid;
        char_item_t item;
    } stage_t;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_MISMATCH  = 2'd1;
    localparam logic [1:0] STATUS_MALFORMED = 2'd2;

    localparam int unsigned POS_W = 5;

    localparam logic [POS_W-1:0] DAMM_FIRST_POS = 5'd2;
    localparam logic [POS_W-1:0] DAMM_LAST_POS  = 5'd10;
    localparam logic [POS_W-1:0] CHECK_POS      = 5'd11;
    localparam logic [POS_W-1:0] LEN_MIN        = 5'd12;
    localparam logic [POS_W-1:0] LEN_MAX        = 5'd15;
    localparam logic [POS_W-1:0] POS_SAT        = 5'd16;

    localparam logic [7:0] DIGIT_ZERO  = 8'h30;
    localparam logic [7:0] DIGIT_NINE  = 8'h39;
    localparam logic [7:0] FIRST_MIN   = 8'h31;
    localparam logic [7:0] FIRST_MAX   = 8'h34;
    localparam logic [6:0] LETTER_BASE = 7'h50;

    // Order-10 Damm quasigroup, row = interim digit, column = new digit
    function automatic logic [3:0] damm_next(input logic [3:0] interim,
                                             input logic [3:0] digit);
        logic [39:0] row;
        row = 40'h0;
        case (interim)
            4'd0:    row = {4'd2, 4'd4, 4'd6, 4'd8, 4'd9, 4'd5, 4'd7, 4'd1, 4'd3, 4'd0};
            4'd1:    row = {4'd3, 4'd6, 4'd8, 4'd4, 4'd5, 4'd1, 4'd2, 4'd9, 4'd0, 4'd7};
            4'd2:    row = {4'd9, 4'd5, 4'd3, 4'd1, 4'd7, 4'd8, 4'd6, 4'd0, 4'd2, 4'd4};
            4'd3:    row = {4'd6, 4'd2, 4'd4, 4'd3, 4'd8, 4'd9, 4'd0, 4'd5, 4'd7, 4'd1};
            4'd4:    row = {4'd8, 4'd7, 4'd9, 4'd5, 4'd4, 4'd0, 4'd3, 4'd2, 4'd1, 4'd6};
            4'd5:    row = {4'd1, 4'd8, 4'd5, 4'd9, 4'd0, 4'd2, 4'd4, 4'd7, 4'd6, 4'd3};
            4'd6:    row = {4'd4, 4'd3, 4'd1, 4'd0, 4'd2, 4'd7, 4'd9, 4'd6, 4'd8, 4'd5};
            4'd7:    row = {4'd7, 4'd1, 4'd0, 4'd2, 4'd6, 4'd3, 4'd5, 4'd4, 4'd9, 4'd8};
            4'd8:    row = {4'd5, 4'd0, 4'd2, 4'd7, 4'd1, 4'd6, 4'd8, 4'd3, 4'd4, 4'd9};
            4'd9:    row = {4'd0, 4'd9, 4'd7, 4'd6, 4'd3, 4'd4, 4'd1, 4'd8, 4'd5, 4'd2};
            default: row = 40'h0;
        endcase
        if (digit > 4'd9)
            return 4'd0;
        return row[digit*4 +: 4];
    endfunction

endpackage

`default_nettype wire

/* rtl/dlcv_in_reg.sv */
`timescale 1ns / 1ps
`default_nettype none

module dlcv_in_reg
    import dlcv_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       char_valid,
    output logic            char_stall,
    input  wire char_item_t char_item,
    input  wire logic       take,
    output stage_t          stage
);

    logic       valid_reg;
    logic       valid_next;
    char_item_t item_reg;
    logic       load;

    // Refill whenever the slot is empty or its item leaves this cycle
    assign load       = !valid_reg || take;
    assign char_stall = !load;
    assign valid_next = load ? char_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && char_valid)
        begin
            item_reg <= char_item;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

endmodule

`default_nettype wire

/* rtl/dlcv_core.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "damm_letter_check_validator_assert.svh"

module dlcv_core
    import dlcv_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire stage_t stage,
    output logic        take,
    output logic        result_valid,
    input  wire logic   result_stall,
    output result_item_t result_item
);

    logic [POS_W-1:0] pos_reg,       pos_next;
    logic [3:0]       interim_reg,   interim_next;
    logic             malformed_reg, malformed_next;
    logic             mismatch_reg,  mismatch_next;
    logic             out_valid_reg, out_valid_next;
    result_item_t     out_item_reg,  out_item_next;

    logic [7:0]       ch;
    logic             last;
    logic             is_digit;
    logic             out_free;
    logic [POS_W-1:0] length;
    logic [6:0]       letter;
    logic             bad;

    assign ch       = stage.item.char_code;
    assign last     = stage.item.last_char;
    assign is_digit = (ch >= DIGIT_ZERO) && (ch <= DIGIT_NINE);
    assign out_free = !out_valid_reg || !result_stall;

    // An item with no result never waits on the output side
    assign take = stage.valid && (!last || out_free);

    always_comb
    begin
        interim_next   = interim_reg;
        malformed_next = malformed_reg;
        mismatch_next  = mismatch_reg;
        pos_next       = pos_reg;
        out_item_next  = out_item_reg;
        length         = pos_reg + 5'd1;
        bad            = 1'b0;
        letter         = 7'd0;

        if (pos_reg == 5'd0)
        begin
            if ((ch < FIRST_MIN) || (ch > FIRST_MAX))
                malformed_next = 1'b1;
        end
        else if ((pos_reg >= DAMM_FIRST_POS) && (pos_reg <= DAMM_LAST_POS))
        begin
            if (is_digit)
                interim_next = damm_next(interim_reg, ch[3:0]);
            else
                malformed_next = 1'b1;
        end
        else if (pos_reg == CHECK_POS)
        begin
            if (ch != {1'b0, LETTER_BASE + {3'd0, interim_reg}})
                mismatch_next = 1'b1;
        end

        if (pos_reg < POS_SAT)
            pos_next = pos_reg + 5'd1;

        letter = LETTER_BASE + {3'd0, interim_next};
        bad    = malformed_next || (length < LEN_MIN) || (length > LEN_MAX);

        if (bad)
        begin
            out_item_next.status          = STATUS_MALFORMED;
            out_item_next.expected_letter = 7'd0;
        end
        else
        begin
            out_item_next.status          = mismatch_next ? STATUS_MISMATCH : STATUS_OK;
            out_item_next.expected_letter = letter;
        end

        // Clear the running state at the end of a number
        if (last)
        begin
            pos_next       = 5'd0;
            interim_next   = 4'd0;
            malformed_next = 1'b0;
            mismatch_next  = 1'b0;
        end

        if (take && last)
            out_valid_next = 1'b1;
        else if (!result_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            interim_reg   <= '0;
            malformed_reg <= 1'b0;
            mismatch_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                pos_reg       <= pos_next;
                interim_reg   <= interim_next;
                malformed_reg <= malformed_next;
                mismatch_reg  <= mismatch_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && last)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_item  = out_item_reg;

    `DLCV_ASSERT(a_pos_saturates, pos_reg <= POS_SAT)
    `DLCV_ASSERT(a_interim_is_digit, interim_reg <= 4'd9)
    `DLCV_ASSERT_NEXT(a_clear_after_last, take && last, (pos_reg == 5'd0) && !malformed_reg && !mismatch_reg && (interim_reg == 4'd0))
    `DLCV_ASSERT(a_malformed_letter_zero, !(out_valid_reg && (out_item_reg.status == STATUS_MALFORMED)) || (out_item_reg.expected_letter == 7'd0))
    `DLCV_ASSERT(a_letter_range, !(out_valid_reg && (out_item_reg.status != STATUS_MALFORMED)) || ((out_item_reg.expected_letter >= LETTER_BASE) && (out_item_reg.expected_letter <= LETTER_BASE + 7'd9)))

endmodule

`default_nettype wire

/* rtl/damm_letter_check_validator.sv */
`timescale 1ns / 1ps
`default_nettype none

// Streaming Damm check-letter validator. One character enters per item on the
// char channel, with last_char marking the end of a number; the block accepts
// one item every cycle while char_stall is low. Each item passes an input
// register and is checked in the following cycle against the running
// position, Damm interim digit and error flags; the item marked last produces
// one result item (status and expected letter P..Y, or 0 with status 2 when
// malformed) in the output register in the cycle after it is taken, and the
// running state clears for the next number. A held result only stalls a
// later last item; characters before it flow on, and those behind it wait.

module damm_letter_check_validator
    import dlcv_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         char_valid,
    output logic              char_stall,
    input  wire char_item_t   char_item,
    output logic              result_valid,
    input  wire logic         result_stall,
    output result_item_t      result_item
);

    stage_t stage;
    logic   take;

    dlcv_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_item  (char_item),
        .take       (take),
        .stage      (stage)
    );

    dlcv_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .stage        (stage),
        .take         (take),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

endmodule

`default_nettype wire
